FILE: rtl/core/dot_bracket_pair_matcher_assert.svh
// assertion macros for the checker file of the dot-bracket pair matcher
// depends on nothing; taken in by `include
`ifndef DOT_BRACKET_PAIR_MATCHER_ASSERT_SVH
`define DOT_BRACKET_PAIR_MATCHER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define DBPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from a condition to a consequent in the next cycle
`define DBPM_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/core/dbpm_pkg.sv
// package of the dot-bracket pair matcher: codes, constants and the queue entry type
// depends on nothing
package dbpm_pkg;

  localparam int unsigned POS_W = 10;
  localparam int unsigned EXP_W = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [7:0] SYM_OPEN = 8'd40;
  localparam logic [7:0] SYM_CLOSE = 8'd41;

  localparam logic [0:0] REG_EXPECTED_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    KIND_UNPAIRED = 2'd0,
    KIND_PAIR     = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_UNCLOSED_OPEN   = 3'd2,
    ST_LEN_MISMATCH    = 3'd3,
    ST_TOO_LONG        = 3'd4
  } status_e;

  // one accepted character as the back end needs it
  typedef struct packed {
    logic             has_char;
    logic             pair;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] partner;
    logic             has_status;
    status_e          status;
  } dbpm_entry_t;

endpackage

FILE: rtl/core/dbpm_front.sv
// front end: accepts characters, keeps the open-bracket stack, counters and sticky error
// depends on dbpm_pkg
module dbpm_front #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned CNT_W_FIFO = 3,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [7:0]                         symbol_i,
  input  logic                               last_symbol_i,
  input  logic [dbpm_pkg::EXP_W-1:0]         expected_length_i,
  input  logic [CNT_W_FIFO-1:0]              fifo_count_i,
  output logic                               enq_valid_o,
  output dbpm_pkg::dbpm_entry_t              enq_entry_o
);
  import dbpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CMP_W = (CNT_W > EXP_W) ? CNT_W : EXP_W;

  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          err_q, err_d;

  logic [POS_W-1:0] stack_mem [MAX_LEN];
  logic [POS_W-1:0] rd_data_q;

  logic             s1_valid_q;
  dbpm_entry_t      s1_entry_q;

  logic             accept;
  logic             too_long;
  logic             is_open, is_close;
  logic             do_push, do_pop;
  logic [CNT_W-1:0] depth_dec;
  logic [CNT_W-1:0] cnt_n, depth_n;
  status_e          err_n, status;
  logic [POS_W-1:0] pos;
  dbpm_entry_t      entry;
  logic             need_entry;
  logic [CNT_W_FIFO-1:0] in_flight;

  assign in_flight = fifo_count_i + CNT_W_FIFO'(s1_valid_q);
  assign full_o    = (in_flight >= CNT_W_FIFO'(FIFO_DEPTH));
  assign accept    = push_i && !full_o;

  assign too_long  = (cnt_q >= CNT_W'(MAX_LEN));
  assign is_open   = (symbol_i == SYM_OPEN);
  assign is_close  = (symbol_i == SYM_CLOSE);
  assign depth_dec = depth_q - 1'b1;
  assign pos       = POS_W'(cnt_q);
  assign do_push   = accept && !too_long && is_open && (depth_q < CNT_W'(MAX_LEN));
  assign do_pop    = accept && !too_long && is_close && (depth_q != '0);

  // per-character update and end-of-string status
  always_comb begin
    cnt_n   = cnt_q;
    depth_n = depth_q;
    err_n   = err_q;
    entry   = '0;
    entry.position = pos;
    if (too_long) begin
      err_n = ST_TOO_LONG;
    end else begin
      cnt_n = cnt_q + 1'b1;
      if (is_open) begin
        if (depth_q < CNT_W'(MAX_LEN)) begin
          depth_n = depth_q + 1'b1;
        end
      end else if (is_close && depth_q != '0) begin
        depth_n        = depth_dec;
        entry.has_char = 1'b1;
        entry.pair     = 1'b1;
      end else begin
        entry.has_char = 1'b1;
        if (is_close && err_q == ST_OK) begin
          err_n = ST_UNMATCHED_CLOSE;
        end
      end
    end

    if (err_n == ST_TOO_LONG) begin
      status = ST_TOO_LONG;
    end else if (CMP_W'(cnt_n) != CMP_W'(expected_length_i)) begin
      status = ST_LEN_MISMATCH;
    end else if (err_n != ST_OK) begin
      status = err_n;
    end else if (depth_n != '0) begin
      status = ST_UNCLOSED_OPEN;
    end else begin
      status = ST_OK;
    end
    entry.has_status = last_symbol_i;
    entry.status     = last_symbol_i ? status : ST_OK;

    cnt_d   = cnt_q;
    depth_d = depth_q;
    err_d   = err_q;
    if (accept) begin
      if (last_symbol_i) begin
        cnt_d   = '0;
        depth_d = '0;
        err_d   = ST_OK;
      end else begin
        cnt_d   = cnt_n;
        depth_d = depth_n;
        err_d   = err_n;
      end
    end
  end

  assign need_entry = accept && (entry.has_char || entry.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      cnt_q      <= '0;
      err_q      <= ST_OK;
      s1_valid_q <= 1'b0;
    end else begin
      depth_q    <= depth_d;
      cnt_q      <= cnt_d;
      err_q      <= err_d;
      s1_valid_q <= need_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (need_entry) begin
      s1_entry_q <= entry;
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      stack_mem[depth_q[AW-1:0]] <= pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      rd_data_q <= stack_mem[depth_dec[AW-1:0]];
    end
  end

  always_comb begin
    enq_entry_o         = s1_entry_q;
    enq_entry_o.partner = s1_entry_q.pair ? rd_data_q : '0;
  end
  assign enq_valid_o = s1_valid_q;

endmodule

FILE: rtl/core/dbpm_fifo.sv
// small queue between front end and back end
// depends on dbpm_pkg
module dbpm_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned CNT_W = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dbpm_pkg::dbpm_entry_t entry_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output dbpm_pkg::dbpm_entry_t head_o,
  output logic [CNT_W-1:0]      count_o
);
  import dbpm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dbpm_entry_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

FILE: rtl/core/dbpm_back.sv
// back end: expands queue entries into result beats held in an output register
// depends on dbpm_pkg
module dbpm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  dbpm_pkg::dbpm_entry_t         head_i,
  output logic                          head_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output dbpm_pkg::kind_e               kind_o,
  output logic [dbpm_pkg::POS_W-1:0]    position_o,
  output logic [dbpm_pkg::POS_W-1:0]    partner_o,
  output dbpm_pkg::status_e             status_o,
  output logic                          last_result_o
);
  import dbpm_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic             char_done_q, char_done_d;
  kind_e            kind_q, kind_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] partner_q, partner_d;
  status_e          status_q, status_d;
  logic             last_q, last_d;
  logic             load, emit, emit_char;

  assign load      = !out_valid_q || pop_i;
  assign emit      = load && head_valid_i;
  assign emit_char = head_i.has_char && !char_done_q;

  always_comb begin
    if (emit_char) begin
      kind_d    = head_i.pair ? KIND_PAIR : KIND_UNPAIRED;
      pos_d     = head_i.position;
      partner_d = head_i.partner;
      status_d  = ST_OK;
      last_d    = 1'b0;
    end else begin
      kind_d    = KIND_STATUS;
      pos_d     = '0;
      partner_d = '0;
      status_d  = head_i.status;
      last_d    = 1'b1;
    end
    head_pop_o  = emit && !(emit_char && head_i.has_status);
    char_done_d = emit ? (emit_char && head_i.has_status) : char_done_q;
    out_valid_d = emit ? 1'b1 : (load ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      char_done_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      char_done_q <= char_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= kind_d;
      pos_q     <= pos_d;
      partner_q <= partner_d;
      status_q  <= status_d;
      last_q    <= last_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign kind_o        = kind_q;
  assign position_o    = pos_q;
  assign partner_o     = partner_q;
  assign status_o      = status_q;
  assign last_result_o = last_q;

endmodule

FILE: rtl/core/dot_bracket_pair_matcher.sv
// dot-bracket pair matcher. One structure character is accepted per clock
// while the result side keeps draining; a character's beat passes through the
// front end stage register that reads the open-bracket stack, then the queue,
// then the output register before it shows on the result port. The stack is a
// MAX_LEN x 10 memory with one write port and one registered read port, so
// every character costs at most a single push or pop and the rate is one beat
// per cycle while the result side keeps draining. A '(' gives no result; a
// matched ')' gives a pair beat; any other byte, an unmatched ')' included,
// gives an unpaired beat. The final character gives its own beat, if any, and
// then a status beat. full rises once FIFO_DEPTH entries are queued or in the
// stage ahead of the queue. expected_length sits at byte address 0 of the APB
// port; write it only while the block is idle. No clearing pass follows reset.
// Characters past MAX_LEN give no character beat.
// depends on dbpm_pkg, dbpm_front, dbpm_fifo, dbpm_back
module dot_bracket_pair_matcher #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // character side
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    symbol_i,
  input  logic                          last_symbol_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    kind_o,
  output logic [dbpm_pkg::POS_W-1:0]    position_o,
  output logic [dbpm_pkg::POS_W-1:0]    partner_o,
  output logic [2:0]                    status_o,
  output logic                          last_result_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpm_pkg::ADDR_W-1:0]   paddr,
  input  logic [dbpm_pkg::DATA_W-1:0]   pwdata,
  output logic [dbpm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import dbpm_pkg::*;

  localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 2);

  logic [EXP_W-1:0]  exp_len_q;
  logic              cfg_wr;
  logic [0:0]        reg_idx;

  logic              enq_valid;
  dbpm_entry_t       enq_entry;
  logic              head_valid;
  dbpm_entry_t       head;
  logic              head_pop;
  logic [FCNT_W-1:0] fifo_count;
  kind_e             kind;
  status_e           status;

  // register decode: the word index is paddr[2], low bits are byte offset
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
    end else if (cfg_wr && reg_idx == REG_EXPECTED_LENGTH) begin
      exp_len_q <= pwdata[EXP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_EXPECTED_LENGTH) begin
      prdata = DATA_W'(exp_len_q);
    end
  end

  // front end: classify characters, update the stack and counters
  dbpm_front #(
    .MAX_LEN    (MAX_LEN),
    .CNT_W_FIFO (FCNT_W),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .symbol_i          (symbol_i),
    .last_symbol_i     (last_symbol_i),
    .expected_length_i (exp_len_q),
    .fifo_count_i      (fifo_count),
    .enq_valid_o       (enq_valid),
    .enq_entry_o       (enq_entry)
  );

  // decoupling queue
  dbpm_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (FCNT_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq_valid),
    .entry_i (enq_entry),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // back end: character beat, then status beat on the last character
  dbpm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .kind_o        (kind),
    .position_o    (position_o),
    .partner_o     (partner_o),
    .status_o      (status),
    .last_result_o (last_result_o)
  );

  assign kind_o   = kind;
  assign status_o = status;

endmodule

FILE: rtl/core/dbpm_checker.sv
// port-level checker for the dot-bracket pair matcher, bound to the top level
// depends on dbpm_pkg and dot_bracket_pair_matcher_assert.svh
`include "dot_bracket_pair_matcher_assert.svh"

module dbpm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       empty,
  input logic                       pop,
  input logic [1:0]                 kind_o,
  input logic [dbpm_pkg::POS_W-1:0] position_o,
  input logic [dbpm_pkg::POS_W-1:0] partner_o,
  input logic [2:0]                 status_o,
  input logic                       last_result_o
);
  import dbpm_pkg::*;

  logic is_status;

  assign is_status = (kind_o == KIND_STATUS);

  `DBPM_ASSERT(a_last_marks_status, clk_i, rst_ni, empty || (is_status == last_result_o), "last_result must flag exactly the status beat")
  `DBPM_ASSERT(a_char_status_zero, clk_i, rst_ni, empty || is_status || status_o == ST_OK, "character beat carries a nonzero status")
  `DBPM_ASSERT(a_status_fields_zero, clk_i, rst_ni, empty || !is_status || (position_o == '0 && partner_o == '0), "status beat carries a position")
  `DBPM_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(kind_o) && $stable(status_o), "result changed while stalled")

endmodule

bind dot_bracket_pair_matcher dbpm_checker u_checker (.*);

FILE: tb/tb.sv
// self-checking testbench of the dot-bracket pair matcher: register access, directed strings,
// back-pressure, an over-long string and random strings, all checked beat by beat
// depends on dbpm_pkg and dot_bracket_pair_matcher
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbpm_pkg::*;

  localparam int unsigned MAX_LEN = 1024;
  // cycles to let the block settle before a register write
  localparam int unsigned IDLE_CYCLES = 8;
  // cycles without any accepted beat before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned RX_HOLD_CYCLES = 300;

  // register map: expected_length at index 0, index 1 is not implemented
  localparam logic [0:0] REG_SPARE = 1'b1;
  localparam logic [ADDR_W-1:0] EXP_LEN_ADDR = {REG_EXPECTED_LENGTH, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  localparam logic [7:0] SYM_DOT = 8'd46;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  // one result beat as it should appear on the result ports
  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] partner;
    status_e          status;
    logic             last;
  } record_t;

  typedef logic [7:0] sym_q_t[$];

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [7:0]        symbol_i = '0;
  logic              last_symbol_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [1:0]        kind_o;
  logic [POS_W-1:0]  position_o;
  logic [POS_W-1:0]  partner_o;
  logic [2:0]        status_o;
  logic              last_result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dot_bracket_pair_matcher #(
    .MAX_LEN(MAX_LEN)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .position_o    (position_o),
    .partner_o     (partner_o),
    .status_o      (status_o),
    .last_result_o (last_result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor state: open-bracket stack, counters, sticky error, register copy
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] open_stack [MAX_LEN];
  int unsigned      open_depth = 0;
  int unsigned      char_count = 0;
  status_e          sticky_err = ST_OK;
  logic [EXP_W-1:0] exp_len = '0;

  // result beats still owed by the block, oldest first
  record_t pending_records[$];

  // bookkeeping
  int unsigned fail_count = 0;
  int unsigned n_strings = 0;
  int unsigned n_chars = 0;
  int unsigned n_pairs = 0;
  int unsigned n_unpaired = 0;
  int unsigned n_status = 0;
  int unsigned status_seen[5];
  int unsigned full_stalls = 0;
  int unsigned stall_cycles = 0;

  // sender and receiver controls
  bit          tx_gaps_on = 1'b1;
  int unsigned tx_burst_left = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_tick = 0;

  // work out the beats one accepted character causes
  task automatic match_symbol(input logic [7:0] sym, input logic fin);
    record_t     r;
    int unsigned pos;
    status_e     st;
    if (char_count >= MAX_LEN) begin
      // too long: no per-character beat, overrides any earlier error
      sticky_err = ST_TOO_LONG;
    end else begin
      pos = char_count;
      char_count++;
      if (sym == SYM_OPEN) begin
        if (open_depth < MAX_LEN) begin
          open_stack[open_depth] = pos[POS_W-1:0];
          open_depth++;
        end
      end else if (sym == SYM_CLOSE && open_depth > 0) begin
        open_depth--;
        r = '{KIND_PAIR, pos[POS_W-1:0], open_stack[open_depth], ST_OK, 1'b0};
        pending_records = {pending_records, r};
      end else begin
        // a close with nothing open is an unmatched close, first error wins
        if (sym == SYM_CLOSE && sticky_err == ST_OK) sticky_err = ST_UNMATCHED_CLOSE;
        r = '{KIND_UNPAIRED, pos[POS_W-1:0], '0, ST_OK, 1'b0};
        pending_records = {pending_records, r};
      end
    end
    if (fin) begin
      // status priority: too long, then length, then recorded error, then open left
      if (sticky_err == ST_TOO_LONG) st = ST_TOO_LONG;
      else if (char_count != exp_len) st = ST_LEN_MISMATCH;
      else if (sticky_err != ST_OK) st = sticky_err;
      else if (open_depth > 0) st = ST_UNCLOSED_OPEN;
      else st = ST_OK;
      r = '{KIND_STATUS, '0, '0, st, 1'b1};
      pending_records = {pending_records, r};
      open_depth = 0;
      char_count = 0;
      sticky_err = ST_OK;
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: compare each accepted beat with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beat
    record_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_records.size() == 0) begin
        fail_count++;
        $error("result beat with nothing expected: kind %0d position %0d status %0d",
               kind_o, position_o, status_o);
      end else begin
        want = pending_records.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind_o));
        check_field("position", 16'(want.position), 16'(position_o));
        check_field("partner", 16'(want.partner), 16'(partner_o));
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("last_result", 16'(want.last), 16'(last_result_o));
        case (want.kind)
          KIND_PAIR: n_pairs++;
          KIND_UNPAIRED: n_unpaired++;
          default: begin
            n_status++;
            status_seen[want.status]++;
          end
        endcase
      end
    end
  end

  // receiver: pop on a pattern of its own, with a long hold-off on request
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: pop <= 1'b1;
        RX_RANDOM: pop <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: pop <= ((rx_tick % 11) < 6);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog: give up when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (push && full) full_stalls++;
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------

  // offer one character and wait until it is accepted
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    int unsigned gap;
    if (tx_gaps_on) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, 8);
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
        tx_burst_left = $urandom_range(1, 16);
      end
      tx_burst_left--;
    end
    push <= 1'b1;
    symbol_i <= sym;
    last_symbol_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    match_symbol(sym, fin);
    n_chars++;
  endtask

  task automatic send_string(input sym_q_t s);
    for (int i = 0; i < s.size(); i++) send_symbol(s[i], i == s.size() - 1);
    n_strings++;
  endtask

  // stop sending, wait for every owed beat, then let the pipeline settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup, access, then idle
  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (addr[ADDR_W-1:2] == REG_EXPECTED_LENGTH) exp_len = data[EXP_W-1:0];
  endtask

  // apb read of expected_length against the predictor's copy
  task automatic reg_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= EXP_LEN_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== DATA_W'(exp_len)) begin
      fail_count++;
      $error("prdata: expected %0d, got %0d", exp_len, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // string builders
  // ---------------------------------------------------------------------------

  // any byte that is not a bracket, mostly the dot
  function automatic logic [7:0] plain_symbol();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) return SYM_DOT;
    b = 8'($urandom_range(0, 255));
    if (b == SYM_OPEN || b == SYM_CLOSE) b = SYM_DOT;
    return b;
  endfunction

  // brackets weighted up, anything goes
  function automatic logic [7:0] noise_symbol();
    case ($urandom_range(0, 2))
      0: return SYM_OPEN;
      1: return SYM_CLOSE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed structure of exactly len characters
  function automatic sym_q_t build_balanced(int unsigned len);
    sym_q_t      s;
    int unsigned depth;
    int unsigned left;
    int unsigned pick;
    depth = 0;
    for (int unsigned i = 0; i < len; i++) begin
      left = len - i;
      pick = $urandom_range(0, 2);
      if (depth == left) begin
        s = {s, SYM_CLOSE};
        depth--;
      end else if (pick == 0 && depth + 2 <= left) begin
        s = {s, SYM_OPEN};
        depth++;
      end else if (pick == 1 && depth > 0) begin
        s = {s, SYM_CLOSE};
        depth--;
      end else begin
        s = {s, plain_symbol()};
      end
    end
    return s;
  endfunction

  // well-formed string with one character replaced, dropped or added
  function automatic sym_q_t build_broken(int unsigned len);
    sym_q_t      s;
    int unsigned idx;
    s = build_balanced(len);
    idx = $urandom_range(0, len - 1);
    case ($urandom_range(0, 2))
      0: s[idx] = noise_symbol();
      1: if (s.size() > 1) s.delete(idx);
      default: s.insert(idx, noise_symbol());
    endcase
    return s;
  endfunction

  function automatic sym_q_t build_noise(int unsigned len);
    sym_q_t s;
    for (int unsigned i = 0; i < len; i++) s = {s, noise_symbol()};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value, both width extremes, the unimplemented address, readback
  task automatic test_register_access();
    reg_check();
    reg_write(EXP_LEN_ADDR, DATA_W'(MAX_LEN));
    reg_check();
    reg_write(EXP_LEN_ADDR, DATA_W'(2047));
    reg_check();
    reg_write(EXP_LEN_ADDR, '0);
    reg_check();
    // a write to index 1 must leave expected_length alone
    reg_write(SPARE_ADDR, $urandom());
    reg_check();
    send_string('{SYM_DOT, SYM_OPEN, SYM_CLOSE});
    wait_idle();
    reg_write(EXP_LEN_ADDR, DATA_W'(5));
    reg_check();
    send_string('{SYM_OPEN, SYM_OPEN, SYM_DOT, SYM_CLOSE, SYM_CLOSE});
    wait_idle();
  endtask

  // byte extremes, bracket neighbors and every status code but too long, by hand
  task automatic test_directed_cases();
    tx_gaps_on = 1'b0;
    reg_write(EXP_LEN_ADDR, DATA_W'(3));
    send_string('{SYM_OPEN, 8'h00, SYM_CLOSE});           // clean pair
    send_string('{SYM_CLOSE, 8'hFF, SYM_DOT});            // unmatched close
    send_string('{SYM_OPEN, SYM_OPEN, 8'd39});            // unclosed open
    send_string('{8'd42, SYM_CLOSE});                     // length wins over close error
    send_string('{SYM_CLOSE, SYM_OPEN, SYM_CLOSE});       // error stays after a good pair
    send_string('{SYM_OPEN});                             // lone open, short
    wait_idle();
    reg_write(EXP_LEN_ADDR, DATA_W'(1));
    send_string('{SYM_DOT});                              // one character, ok
    wait_idle();
    reg_write(EXP_LEN_ADDR, '0);
    send_string('{SYM_OPEN});                             // nothing can match zero
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so full must rise
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    reg_write(EXP_LEN_ADDR, DATA_W'(20));
    rx_hold_req = RX_HOLD_CYCLES;
    repeat (2) send_string(build_balanced(20));
    // sender pauses until every owed beat has come
    wait_idle();
    tx_gaps_on = 1'b1;
  endtask

  // one string past MAX_LEN: an early unmatched close, deep nesting, then too long
  task automatic test_long_strings();
    sym_q_t s;
    rx_mode = RX_RANDOM;
    reg_write(EXP_LEN_ADDR, DATA_W'(MAX_LEN));
    reg_check();
    s = {};
    s = {s, SYM_CLOSE};
    for (int i = 1; i < MAX_LEN; i++) s = {s, SYM_OPEN};
    // both of these arrive with the count already at MAX_LEN
    s = {s, SYM_CLOSE};
    s = {s, plain_symbol()};
    send_string(s);
    wait_idle();
  endtask

  // phases of random strings, a register setting per phase
  task automatic test_random_strings();
    int unsigned rand_chars;
    int unsigned len;
    int unsigned pick;
    sym_q_t      s;
    rand_chars = 0;
    while (rand_chars < RANDOM_ITEMS) begin
      // mostly short strings, now and then a longer one
      if ($urandom_range(0, 9) == 0) len = $urandom_range(25, 80);
      else len = $urandom_range(1, 24);
      wait_idle();
      pick = $urandom_range(0, 7);
      case (pick)
        0: reg_write(EXP_LEN_ADDR, '0);
        1: reg_write(EXP_LEN_ADDR, DATA_W'(MAX_LEN));
        2: reg_write(EXP_LEN_ADDR, DATA_W'($urandom_range(0, 64)));
        default: reg_write(EXP_LEN_ADDR, DATA_W'(len));
      endcase
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (6) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) s = build_balanced(len);
        else if (pick < 17) s = build_broken(len);
        else s = build_noise($urandom_range(1, len + 3));
        send_string(s);
        rand_chars += s.size();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_cases();
    test_backpressure();
    test_long_strings();
    test_random_strings();
    wait_idle();
    if (pending_records.size() != 0) begin
      fail_count++;
      $error("%0d result beats never arrived", pending_records.size());
    end
    $display("covered %0d strings, %0d characters: %0d pair, %0d unpaired, %0d status beats",
             n_strings, n_chars, n_pairs, n_unpaired, n_status);
    $display("status ok %0d, unmatched %0d, unclosed %0d, length %0d, too long %0d; %0d full stalls",
             status_seen[ST_OK], status_seen[ST_UNMATCHED_CLOSE], status_seen[ST_UNCLOSED_OPEN],
             status_seen[ST_LEN_MISMATCH], status_seen[ST_TOO_LONG], full_stalls);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/dbpm_pkg.sv
rtl/core/dbpm_front.sv
rtl/core/dbpm_fifo.sv
rtl/core/dbpm_back.sv
rtl/core/dot_bracket_pair_matcher.sv
rtl/core/dbpm_checker.sv
tb/tb.sv
